// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mcmf_pkg.sv =====
package mcmf_pkg;

  localparam int CAP_W  = 16;
  localparam int COST_W = 48;
  localparam int FLOW_W = 22;
  localparam int DIST_W = 32;
  localparam int IN_NODE_W = 6;
  localparam int W_W = 15;

  localparam logic [CAP_W-1:0]  CAP_MAX  = 16'hFFFF;
  localparam logic [FLOW_W:0]   FLOW_MAX = 23'd4194303;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_SOLVE = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_LOAD       = 5'd1;
  localparam op_t OP_CLR_STEP   = 5'd2;
  localparam op_t OP_ADD_RD     = 5'd3;
  localparam op_t OP_ADD_WF     = 5'd4;
  localparam op_t OP_ADD_WR     = 5'd5;
  localparam op_t OP_SOLVE_INIT = 5'd6;
  localparam op_t OP_S_INIT     = 5'd7;
  localparam op_t OP_POP        = 5'd8;
  localparam op_t OP_POP2       = 5'd9;
  localparam op_t OP_POP3       = 5'd10;
  localparam op_t OP_VRD        = 5'd11;
  localparam op_t OP_VEV        = 5'd12;
  localparam op_t OP_B_INIT     = 5'd13;
  localparam op_t OP_B_RD       = 5'd14;
  localparam op_t OP_B_RD2      = 5'd15;
  localparam op_t OP_B_MIN      = 5'd16;
  localparam op_t OP_A_INIT     = 5'd17;
  localparam op_t OP_A_RD       = 5'd18;
  localparam op_t OP_A_P        = 5'd19;
  localparam op_t OP_A_W1       = 5'd20;
  localparam op_t OP_A_R2       = 5'd21;
  localparam op_t OP_A_W2       = 5'd22;
  localparam op_t OP_ACC1       = 5'd23;
  localparam op_t OP_ACC2       = 5'd24;
  localparam op_t OP_ACC3       = 5'd25;
  localparam op_t OP_OUT        = 5'd26;

  typedef struct packed {
    logic [1:0] kind;
    logic       add_bad;
    logic       solve_bad;
    logic       clr_last;
    logic       cnt_zero;
    logic       v_last;
    logic       abort;
    logic       found;
    logic       at_src;
    logic       steps_ge;
    logic       bott_zero;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/mcmf_dp.sv =====
`include "assert_macros.svh"

module mcmf_dp import mcmf_pkg::*; #(
  parameter int N = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  output stat_t       st,
  input  logic [1:0]  in_kind,
  input  logic [54:0] in_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);

  localparam int NW = $clog2(N);
  localparam int AW = $clog2(N * N);
  localparam int CW = $clog2(N + 1);

  function automatic logic [AW-1:0] pair(input logic [NW-1:0] r, input logic [NW-1:0] c);
    return AW'(AW'(r) * AW'(N) + AW'(c));
  endfunction

  logic [1:0]           kind;
  logic [IN_NODE_W-1:0] a_in, b_in, src_in, snk_in;
  logic [CAP_W-1:0]     c_in;
  logic [W_W-1:0]       w_in;

  logic [CAP_W-1:0]  cap_mem  [N*N];
  logic [CAP_W-1:0]  cost_mem [N*N];
  logic [DIST_W-1:0] dist_mem [N];
  logic [NW-1:0]     plen_mem [N];
  logic [NW-1:0]     pred_mem [N];
  logic [NW-1:0]     q_mem    [N];

  logic [CAP_W-1:0]  cap_rd, cost_rd;
  logic [DIST_W-1:0] dist_rd;
  logic [NW-1:0]     plen_rd, pred_rd, q_rd;

  logic [AW-1:0]     clr_idx;
  logic [NW-1:0]     head;
  logic [CW-1:0]     count;
  logic [N-1:0]      reached, queued;
  logic [NW-1:0]     u, v, p, steps;
  logic              steps_hi;
  logic [DIST_W-1:0] du;
  logic [NW-1:0]     lu;
  logic [CAP_W-1:0]  bott;
  logic [FLOW_W-1:0] flow;
  logic [COST_W-1:0] cost, prod;
  logic [FLOW_W-1:0] res_flow;
  logic [COST_W-1:0] res_cost;

  logic [NW-1:0]     a, b, src, snk;
  logic [AW-1:0]     cap_addr, cost_addr;
  logic              cap_we, cost_we;
  logic [CAP_W-1:0]  cap_wd, cost_wd;
  logic [NW-1:0]     dist_ra;
  logic [CAP_W:0]    cap_sum;
  logic [DIST_W-1:0] nd;
  logic              relax, do_upd, do_enq;
  logic [NW:0]       tail_sum;
  logic [NW-1:0]     tail;
  logic [FLOW_W:0]   flow_sum;
  logic signed [CAP_W+DIST_W:0] prod_full;

  assign a   = NW'(a_in);
  assign b   = NW'(b_in);
  assign src = NW'(src_in);
  assign snk = NW'(snk_in);

  always_comb begin
    cap_addr  = clr_idx;
    cost_addr = clr_idx;
    cap_we    = 1'b0;
    cost_we   = 1'b0;
    cap_wd    = '0;
    cost_wd   = '0;
    cap_sum   = '0;
    dist_ra   = v;
    case (op)
      OP_CLR_STEP: begin
        cap_we  = 1'b1;
        cost_we = 1'b1;
      end
      OP_ADD_RD: cap_addr = pair(a, b);
      OP_ADD_WF: begin
        cap_addr  = pair(a, b);
        cost_addr = pair(a, b);
        cap_sum   = {1'b0, cap_rd} + {1'b0, c_in};
        cap_wd    = cap_sum[CAP_W] ? CAP_MAX : cap_sum[CAP_W-1:0];
        cap_we    = 1'b1;
        cost_wd   = {1'b0, w_in};
        cost_we   = 1'b1;
      end
      OP_ADD_WR: begin
        cost_addr = pair(b, a);
        cost_wd   = CAP_W'(-{1'b0, w_in});
        cost_we   = 1'b1;
      end
      OP_POP2: dist_ra = q_rd;
      OP_VRD: begin
        cap_addr  = pair(u, v);
        cost_addr = pair(u, v);
      end
      OP_B_RD2, OP_A_P: cap_addr = pair(pred_rd, v);
      OP_A_W1: begin
        cap_addr = pair(p, v);
        cap_wd   = cap_rd - bott;
        cap_we   = 1'b1;
      end
      OP_A_R2: cap_addr = pair(v, p);
      OP_A_W2: begin
        cap_addr = pair(v, p);
        cap_sum  = {1'b0, cap_rd} + {1'b0, bott};
        cap_wd   = cap_sum[CAP_W] ? CAP_MAX : cap_sum[CAP_W-1:0];
        cap_we   = 1'b1;
      end
      OP_ACC1: dist_ra = snk;
      default: ;
    endcase
  end

  assign nd       = du + {{(DIST_W-CAP_W){cost_rd[CAP_W-1]}}, cost_rd};
  assign relax    = (cap_rd != '0) && (!reached[v] || $signed(nd) < $signed(dist_rd));
  assign st.abort = relax && (({1'b0, lu} + 1'b1) >= (NW+1)'(N));
  assign do_upd   = (op == OP_VEV) && relax && !st.abort;
  assign do_enq   = do_upd && !queued[v] && (count < CW'(N));
  assign tail_sum = {1'b0, head} + (NW+1)'(count);
  assign tail     = (tail_sum >= (NW+1)'(N)) ? NW'(tail_sum - (NW+1)'(N)) : NW'(tail_sum);
  assign flow_sum = {1'b0, flow} + (FLOW_W+1)'(bott);
  assign prod_full = $signed({1'b0, bott}) * $signed(dist_rd);

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_addr] <= cap_wd;
    cap_rd <= cap_mem[cap_addr];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_addr] <= cost_wd;
    cost_rd <= cost_mem[cost_addr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_S_INIT) dist_mem[src] <= '0;
    else if (do_upd) dist_mem[v] <= nd;
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (op == OP_S_INIT) plen_mem[src] <= '0;
    else if (do_upd) plen_mem[v] <= lu + 1'b1;
    plen_rd <= plen_mem[q_rd];
  end

  always_ff @(posedge clk) begin
    if (op == OP_S_INIT) pred_mem[src] <= src;
    else if (do_upd) pred_mem[v] <= u;
    pred_rd <= pred_mem[v];
  end

  always_ff @(posedge clk) begin
    if (op == OP_S_INIT) q_mem[0] <= src;
    else if (do_enq) q_mem[tail] <= v;
    if (op == OP_POP) q_rd <= q_mem[head];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      head     <= '0;
      count    <= '0;
      reached  <= '0;
      queued   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (op == OP_OUT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (op)
        OP_CLR_STEP: clr_idx <= st.clr_last ? '0 : clr_idx + 1'b1;
        OP_S_INIT: begin
          head    <= '0;
          count   <= CW'(1);
          reached <= {{(N-1){1'b0}}, 1'b1} << src;
          queued  <= {{(N-1){1'b0}}, 1'b1} << src;
        end
        OP_POP: begin
          head  <= (head == NW'(N - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end
        OP_POP2: queued[q_rd] <= 1'b0;
        OP_VEV: begin
          if (do_upd) reached[v] <= 1'b1;
          if (do_enq) begin
            queued[v] <= 1'b1;
            count     <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        kind   <= in_kind;
        a_in   <= in_data[5:0];
        b_in   <= in_data[11:6];
        c_in   <= in_data[27:12];
        w_in   <= in_data[42:28];
        src_in <= in_data[48:43];
        snk_in <= in_data[54:49];
      end
      OP_SOLVE_INIT: begin
        flow <= '0;
        cost <= '0;
      end
      OP_POP2: begin
        u <= q_rd;
        v <= '0;
      end
      OP_POP3: begin
        du <= dist_rd;
        lu <= plen_rd;
      end
      OP_VEV: v <= v + 1'b1;
      OP_B_INIT: begin
        v        <= snk;
        steps    <= '0;
        steps_hi <= 1'b0;
        bott     <= CAP_MAX;
      end
      OP_B_RD2, OP_A_P: p <= pred_rd;
      OP_B_MIN: begin
        if (cap_rd < bott) bott <= cap_rd;
        v <= p;
        {steps_hi, steps} <= {steps_hi, steps} + 1'b1;
      end
      OP_A_INIT: v <= snk;
      OP_A_W2: v <= p;
      OP_ACC2: begin
        prod <= COST_W'(prod_full);
        flow <= (flow_sum > FLOW_MAX) ? FLOW_MAX[FLOW_W-1:0] : flow_sum[FLOW_W-1:0];
      end
      OP_ACC3: cost <= cost + prod;
      OP_OUT: begin
        res_flow <= flow;
        res_cost <= cost;
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, res_cost, res_flow};

  assign st.kind      = kind;
  assign st.add_bad   = (32'(a_in) >= 32'(N)) || (32'(b_in) >= 32'(N)) || (a_in == b_in);
  assign st.solve_bad = (32'(src_in) >= 32'(N)) || (32'(snk_in) >= 32'(N)) || (src_in == snk_in);
  assign st.clr_last  = (clr_idx == AW'(N * N - 1));
  assign st.cnt_zero  = (count == '0);
  assign st.v_last    = (v == NW'(N - 1));
  assign st.found     = reached[snk];
  assign st.at_src    = (v == src);
  assign st.steps_ge  = (({steps_hi, steps}) >= (NW+1)'(N));
  assign st.bott_zero = (bott == '0);
  assign st.out_free  = !m_tvalid || m_tready;

  `ASSERT_IMPL(a_queue_bound, clk, rst, 1'b1, count <= CW'(N))
  `ASSERT_NEXT(a_pop_shrinks, clk, rst, op == OP_POP, count == $past(count) - 1'b1)

endmodule

// ===== sv/mcmf_ctrl.sv =====
`include "assert_macros.svh"

module mcmf_ctrl import mcmf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t st,
  output op_t   op
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DEC   = 5'd1;
  localparam logic [4:0] ST_CLR   = 5'd2;
  localparam logic [4:0] ST_ADD1  = 5'd3;
  localparam logic [4:0] ST_ADD2  = 5'd4;
  localparam logic [4:0] ST_ADD3  = 5'd5;
  localparam logic [4:0] ST_SINIT = 5'd6;
  localparam logic [4:0] ST_QCHK  = 5'd7;
  localparam logic [4:0] ST_POP   = 5'd8;
  localparam logic [4:0] ST_POP2  = 5'd9;
  localparam logic [4:0] ST_POP3  = 5'd10;
  localparam logic [4:0] ST_VRD   = 5'd11;
  localparam logic [4:0] ST_VEV   = 5'd12;
  localparam logic [4:0] ST_SEND  = 5'd13;
  localparam logic [4:0] ST_BINIT = 5'd14;
  localparam logic [4:0] ST_BCHK  = 5'd15;
  localparam logic [4:0] ST_BRD   = 5'd16;
  localparam logic [4:0] ST_BRD2  = 5'd17;
  localparam logic [4:0] ST_BMIN  = 5'd18;
  localparam logic [4:0] ST_AINIT = 5'd19;
  localparam logic [4:0] ST_ACHK  = 5'd20;
  localparam logic [4:0] ST_ARD   = 5'd21;
  localparam logic [4:0] ST_AP    = 5'd22;
  localparam logic [4:0] ST_AW1   = 5'd23;
  localparam logic [4:0] ST_AR2   = 5'd24;
  localparam logic [4:0] ST_AW2   = 5'd25;
  localparam logic [4:0] ST_ACC1  = 5'd26;
  localparam logic [4:0] ST_ACC2  = 5'd27;
  localparam logic [4:0] ST_ACC3  = 5'd28;
  localparam logic [4:0] ST_OUT   = 5'd29;

  logic [4:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      ST_IDLE: if (s_tvalid) begin
        op         = OP_LOAD;
        state_next = ST_DEC;
      end
      ST_DEC: begin
        op = OP_SOLVE_INIT;
        case (st.kind)
          KIND_CLEAR: state_next = ST_CLR;
          KIND_ADD:   state_next = st.add_bad ? ST_IDLE : ST_ADD1;
          KIND_SOLVE: state_next = st.solve_bad ? ST_OUT : ST_SINIT;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_CLR: begin
        op = OP_CLR_STEP;
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_ADD1: begin
        op         = OP_ADD_RD;
        state_next = ST_ADD2;
      end
      ST_ADD2: begin
        op         = OP_ADD_WF;
        state_next = ST_ADD3;
      end
      ST_ADD3: begin
        op         = OP_ADD_WR;
        state_next = ST_IDLE;
      end
      ST_SINIT: begin
        op         = OP_S_INIT;
        state_next = ST_QCHK;
      end
      ST_QCHK: state_next = st.cnt_zero ? ST_SEND : ST_POP;
      ST_POP: begin
        op         = OP_POP;
        state_next = ST_POP2;
      end
      ST_POP2: begin
        op         = OP_POP2;
        state_next = ST_POP3;
      end
      ST_POP3: begin
        op         = OP_POP3;
        state_next = ST_VRD;
      end
      ST_VRD: begin
        op         = OP_VRD;
        state_next = ST_VEV;
      end
      ST_VEV: begin
        if (st.abort) begin
          state_next = ST_OUT;
        end else begin
          op         = OP_VEV;
          state_next = st.v_last ? ST_QCHK : ST_VRD;
        end
      end
      ST_SEND: state_next = st.found ? ST_BINIT : ST_OUT;
      ST_BINIT: begin
        op         = OP_B_INIT;
        state_next = ST_BCHK;
      end
      ST_BCHK: begin
        if (st.at_src) state_next = st.bott_zero ? ST_OUT : ST_AINIT;
        else state_next = ST_BRD;
      end
      ST_BRD: begin
        op         = OP_B_RD;
        state_next = ST_BRD2;
      end
      ST_BRD2: begin
        op         = OP_B_RD2;
        state_next = ST_BMIN;
      end
      ST_BMIN: begin
        if (st.steps_ge) begin
          state_next = ST_OUT;
        end else begin
          op         = OP_B_MIN;
          state_next = ST_BCHK;
        end
      end
      ST_AINIT: begin
        op         = OP_A_INIT;
        state_next = ST_ACHK;
      end
      ST_ACHK: state_next = st.at_src ? ST_ACC1 : ST_ARD;
      ST_ARD: begin
        op         = OP_A_RD;
        state_next = ST_AP;
      end
      ST_AP: begin
        op         = OP_A_P;
        state_next = ST_AW1;
      end
      ST_AW1: begin
        op         = OP_A_W1;
        state_next = ST_AR2;
      end
      ST_AR2: begin
        op         = OP_A_R2;
        state_next = ST_AW2;
      end
      ST_AW2: begin
        op         = OP_A_W2;
        state_next = ST_ACHK;
      end
      ST_ACC1: begin
        op         = OP_ACC1;
        state_next = ST_ACC2;
      end
      ST_ACC2: begin
        op         = OP_ACC2;
        state_next = ST_ACC3;
      end
      ST_ACC3: begin
        op         = OP_ACC3;
        state_next = ST_SINIT;
      end
      ST_OUT: if (st.out_free) begin
        op         = OP_OUT;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // reset starts with a clearing pass over the matrices
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, s_tvalid && s_tready, state == ST_DEC)
  `ASSERT_NEXT(a_clear_holds, clk, rst, state == ST_CLR && !st.clr_last, state == ST_CLR)

endmodule

// ===== sv/min_cost_max_flow_spfa.sv =====
// Min-cost max-flow engine over a residual capacity matrix and a signed cost matrix of
// MAX_NODES x MAX_NODES entries, held in single-port memories. After reset and after each
// clear request a clearing pass writes every matrix entry while no request is taken. An
// add-edge request adds to the forward capacity and writes both costs. A solve request
// runs queue-based shortest-path searches until no path remains or a search is aborted:
// for each dequeued node the single matrix read port visits the neighbors one at a time,
// and each augmentation walks the path once for the bottleneck and once more to update
// the residual capacities. The run time is graph dependent. One result (total flow,
// total cost) is returned per solve request; clear and add-edge requests return nothing.
module min_cost_max_flow_spfa import mcmf_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // from_node, to_node, capacity, edge_cost, source_node, sink_node
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // max_flow, min_cost
);

  op_t   op;
  stat_t st;

  mcmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .op       (op)
  );

  mcmf_dp #(.N(MAX_NODES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .st       (st),
    .in_kind  (s_tuser),
    .in_data  (s_tdata[54:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
